/* rtl/next_lexicographic_permutation_unit_defines.svh */
// assertion macros for the next lexicographic permutation unit
// no dependencies; taken in by the top level
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_UNIT_DEFINES_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define NLP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nlp check failed: same-cycle rule");

// next-cycle implication, disabled while reset is low
`define NLP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nlp check failed: next-cycle rule");

`endif

/* rtl/nlp_pkg.sv */
// shared constants, codes and sequencer states of the permutation unit
// no dependencies
`default_nettype none

package nlp_pkg;

    localparam int MAX_LEN    = 16;
    localparam int ELEM_WIDTH = 8;

    // fixed field widths of the item and configuration ports
    localparam int CMD_W = 1;
    localparam int POS_W = 4;
    localparam int VAL_W = 8;
    localparam int CFG_W = 5;

    // store address and length counter widths
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int LEN_W = $clog2(MAX_LEN + 1);

    localparam logic [CMD_W-1:0] CMD_LOAD    = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIV_SCAN,
        ST_SUCC_SCAN,
        ST_SWAP_P,
        ST_SWAP_Q,
        ST_REV_CHK,
        ST_REV_RD_LO,
        ST_REV_RD_HI,
        ST_REV_WR_LO,
        ST_REV_WR_HI,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

endpackage

`default_nettype wire

/* rtl/nlp_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module nlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/next_lexicographic_permutation_unit.sv */
// top level of the next lexicographic permutation unit: sequencer, shared compare
// depends on nlp_pkg, nlp_ram and next_lexicographic_permutation_unit_defines.svh
`default_nettype none
`include "next_lexicographic_permutation_unit_defines.svh"

//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | cmd, position, value
//  out     | out_valid / out_ready | out_position, out_value, advanced, last
//  cfg     | cfg_valid / cfg_ready | cfg_data (seq_length)
//
//  a load item gives no result; in_ready stays high
//  an advance scans for the pivot and, if it finds one, for the successor, swaps the
//  two and reverses the tail, then emits every element, held by any output stall;
//  every read goes through the one read port of the sequence store
//  in_ready and cfg_ready are low from an advance of nonzero length until its last result is taken
//  reset clears the sequencer, the output valid and seq_length; the store is not cleared

module next_lexicographic_permutation_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [nlp_pkg::CFG_W-1:0] cfg_data,
    // items in
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [nlp_pkg::CMD_W-1:0] cmd,
    input  wire logic [nlp_pkg::POS_W-1:0] position,
    input  wire logic [nlp_pkg::VAL_W-1:0] value,
    // items out
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic      [nlp_pkg::POS_W-1:0] out_position,
    output logic      [nlp_pkg::VAL_W-1:0] out_value,
    output logic                           advanced,
    output logic                           last
);

    import nlp_pkg::*;

    // control registers
    state_t                 state_reg,      state_next;
    logic                   out_valid_reg,  out_valid_next;
    logic [CFG_W-1:0]       seq_length_reg;
    logic                   arr_vld_reg,    arr_vld_next;

    // working registers
    logic [LEN_W-1:0]       len_reg,        len_next;
    logic [LEN_W-1:0]       k_reg,          k_next;
    logic [IDX_W-1:0]       arr_idx_reg,    arr_idx_next;
    logic [ELEM_WIDTH-1:0]  prev_reg,       prev_next;
    logic [IDX_W-1:0]       p_reg,          p_next;
    logic [ELEM_WIDTH-1:0]  piv_val_reg,    piv_val_next;
    logic                   found_reg,      found_next;
    logic [IDX_W-1:0]       q_reg,          q_next;
    logic [ELEM_WIDTH-1:0]  q_val_reg,      q_val_next;
    logic [IDX_W-1:0]       lo_reg,         lo_next;
    logic [IDX_W-1:0]       hi_reg,         hi_next;
    logic [ELEM_WIDTH-1:0]  lo_val_reg,     lo_val_next;

    // output registers
    logic [POS_W-1:0]       out_pos_reg,    out_pos_next;
    logic [VAL_W-1:0]       out_val_reg,    out_val_next;
    logic                   out_adv_reg,    out_adv_next;
    logic                   out_last_reg,   out_last_next;

    // store ports
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_wr_addr;
    logic [ELEM_WIDTH-1:0]  ram_wr_data;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [ELEM_WIDTH-1:0]  ram_rd_data;

    // shared compare and helpers
    logic [ELEM_WIDTH-1:0]  cmp_a;
    logic                   cmp_lt;
    logic [LEN_W-1:0]       k_inc;
    logic [LEN_W-1:0]       len_eff;
    logic                   in_fire;

    nlp_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (MAX_LEN)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;

    assign out_valid    = out_valid_reg;
    assign out_position = out_pos_reg;
    assign out_value    = out_val_reg;
    assign advanced     = out_adv_reg;
    assign last         = out_last_reg;

    // one comparator serves both scans: the incoming element is always the right operand
    // pivot scan asks prev < cur, successor scan asks pivot < cur
    assign cmp_a  = (state_reg == ST_SUCC_SCAN) ? piv_val_reg : prev_reg;
    assign cmp_lt = (cmp_a < ram_rd_data);

    assign k_inc = k_reg + LEN_W'(1);

    // lengths above the store depth are clamped
    assign len_eff = (32'(seq_length_reg) > MAX_LEN) ? LEN_W'(MAX_LEN)
                                                     : LEN_W'(seq_length_reg);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        arr_vld_next   = 1'b0;
        len_next       = len_reg;
        k_next         = k_reg;
        arr_idx_next   = k_reg[IDX_W-1:0];
        prev_next      = prev_reg;
        p_next         = p_reg;
        piv_val_next   = piv_val_reg;
        found_next     = found_reg;
        q_next         = q_reg;
        q_val_next     = q_val_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        lo_val_next    = lo_val_reg;
        out_pos_next   = out_pos_reg;
        out_val_next   = out_val_reg;
        out_adv_next   = out_adv_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_wr_addr    = IDX_W'(position);
        ram_wr_data    = ELEM_WIDTH'(value);
        ram_rd_addr    = k_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (cmd == CMD_LOAD)
                    begin
                        // loads beyond the store depth are dropped
                        ram_we = (32'(position) < MAX_LEN);
                    end
                    else if (len_eff != '0)
                    begin
                        len_next   = len_eff;
                        k_next     = '0;
                        found_next = 1'b0;
                        state_next = ST_PIV_SCAN;
                    end
                end
            end

            ST_PIV_SCAN:
            begin
                // stream the sequence and keep the rightmost ascent
                if (k_reg < len_reg)
                begin
                    arr_vld_next = 1'b1;
                    k_next       = k_inc;
                end
                if (arr_vld_reg)
                begin
                    prev_next = ram_rd_data;
                    if ((arr_idx_reg != '0) && cmp_lt)
                    begin
                        p_next       = arr_idx_reg - IDX_W'(1);
                        piv_val_next = prev_reg;
                        found_next   = 1'b1;
                    end
                end
                else if (k_reg == len_reg)
                begin
                    if (found_reg)
                    begin
                        k_next     = LEN_W'(p_reg) + LEN_W'(1);
                        state_next = ST_SUCC_SCAN;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            ST_SUCC_SCAN:
            begin
                // last element right of the pivot that beats it is the rightmost one
                if (k_reg < len_reg)
                begin
                    arr_vld_next = 1'b1;
                    k_next       = k_inc;
                end
                if (arr_vld_reg)
                begin
                    if (cmp_lt)
                    begin
                        q_next     = arr_idx_reg;
                        q_val_next = ram_rd_data;
                    end
                end
                else if (k_reg == len_reg)
                begin
                    state_next = ST_SWAP_P;
                end
            end

            ST_SWAP_P:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = p_reg;
                ram_wr_data = q_val_reg;
                state_next  = ST_SWAP_Q;
            end

            ST_SWAP_Q:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = q_reg;
                ram_wr_data = piv_val_reg;
                lo_next     = p_reg + IDX_W'(1);
                hi_next     = IDX_W'(len_reg - LEN_W'(1));
                state_next  = ST_REV_CHK;
            end

            ST_REV_CHK:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = ST_REV_RD_LO;
                end
                else
                begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end
            end

            ST_REV_RD_LO:
            begin
                ram_rd_addr = lo_reg;
                state_next  = ST_REV_RD_HI;
            end

            ST_REV_RD_HI:
            begin
                ram_rd_addr = hi_reg;
                lo_val_next = ram_rd_data;
                state_next  = ST_REV_WR_LO;
            end

            ST_REV_WR_LO:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = lo_reg;
                ram_wr_data = ram_rd_data;
                state_next  = ST_REV_WR_HI;
            end

            ST_REV_WR_HI:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = hi_reg;
                ram_wr_data = lo_val_reg;
                lo_next     = lo_reg + IDX_W'(1);
                hi_next     = hi_reg - IDX_W'(1);
                state_next  = ST_REV_CHK;
            end

            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end

            ST_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_pos_next   = POS_W'(k_reg);
                out_val_next   = VAL_W'(ram_rd_data);
                out_adv_next   = found_reg;
                out_last_next  = (k_inc == len_reg);
                state_next     = ST_EMIT_WAIT;
            end

            ST_EMIT_WAIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // fetch the next element while this one leaves
                        ram_rd_addr = k_inc[IDX_W-1:0];
                        k_next      = k_inc;
                        state_next  = ST_EMIT_LD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            seq_length_reg <= '0;
            arr_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            arr_vld_reg   <= arr_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                seq_length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        k_reg        <= k_next;
        arr_idx_reg  <= arr_idx_next;
        prev_reg     <= prev_next;
        p_reg        <= p_next;
        piv_val_reg  <= piv_val_next;
        found_reg    <= found_next;
        q_reg        <= q_next;
        q_val_reg    <= q_val_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        lo_val_reg   <= lo_val_next;
        out_pos_reg  <= out_pos_next;
        out_val_reg  <= out_val_next;
        out_adv_reg  <= out_adv_next;
        out_last_reg <= out_last_next;
    end

    // no item is taken while a result is on offer
    `NLP_ASSERT_IMP(a_idle_no_result, clk, rst_n, in_ready, !out_valid)
    // the final item of a sequence frees the input
    `NLP_ASSERT_NXT(a_last_frees_input, clk, rst_n, out_valid && out_ready && last, in_ready)
    // an advance with a nonzero length keeps the block busy
    `NLP_ASSERT_NXT(a_advance_busy, clk, rst_n, in_fire && (cmd == CMD_ADVANCE) && (seq_length_reg != '0), !in_ready)
    // emitted positions stay inside the sequence in use
    `NLP_ASSERT_IMP(a_pos_in_range, clk, rst_n, out_valid, LEN_W'(out_position) < len_reg)

endmodule

`default_nettype wire

/* sim/nlp_perm_checker.sv */
`timescale 1ns / 100ps
// result checker for the next lexicographic permutation unit: watches all three channels
// keeps its own copy of the sequence and length, predicts every emitted element
// depends on nlp_pkg
module nlp_perm_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [nlp_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [nlp_pkg::CMD_W-1:0] cmd,
    input  logic [nlp_pkg::POS_W-1:0] position,
    input  logic [nlp_pkg::VAL_W-1:0] value,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [nlp_pkg::POS_W-1:0] out_position,
    input  logic [nlp_pkg::VAL_W-1:0] out_value,
    input  logic                      advanced,
    input  logic                      last,
    output int                        mismatch_count,
    output int                        results_due
);

    import nlp_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic             adv;
        logic             is_last;
    } elem_rec_t;

    logic [VAL_W-1:0] seq_copy [MAX_LEN];
    logic [CFG_W-1:0] length_reg;
    elem_rec_t        elems_due [$];

    // rewrites the first n elements of the copy, returns 0 if already the last
    function automatic bit advance_copy(int n);
        int               p;
        int               q;
        int               lo;
        int               hi;
        bit               found;
        logic [VAL_W-1:0] tmp;
        p     = 0;
        found = 1'b0;
        for (q = 0; q + 1 < n; q++)
        begin
            if (seq_copy[q] < seq_copy[q + 1])
            begin
                p     = q;
                found = 1'b1;
            end
        end
        if (!found)
            return 1'b0;
        q = n - 1;
        while (q > p && seq_copy[q] <= seq_copy[p])
            q--;
        tmp         = seq_copy[p];
        seq_copy[p] = seq_copy[q];
        seq_copy[q] = tmp;
        lo = p + 1;
        hi = n - 1;
        while (lo < hi)
        begin
            tmp          = seq_copy[lo];
            seq_copy[lo] = seq_copy[hi];
            seq_copy[hi] = tmp;
            lo++;
            hi--;
        end
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin : watch
        elem_rec_t head;
        elem_rec_t rec;
        int        n;
        bit        moved;
        if (!rst_n)
        begin
            length_reg     = '0;
            mismatch_count = 0;
            elems_due.delete();
        end
        else
        begin
            // an element leaving now always belongs to an earlier advance
            if (out_valid && out_ready)
            begin
                if (elems_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: element with none due, got pos %0d value %0d adv %0b last %0b",
                             $time, out_position, out_value, advanced, last);
                end
                else
                begin
                    head = elems_due.pop_front();
                    if (out_position !== head.pos)
                    begin
                        mismatch_count++;
                        $display("%0t: out_position expected %0d, got %0d",
                                 $time, head.pos, out_position);
                    end
                    if (out_value !== head.val)
                    begin
                        mismatch_count++;
                        $display("%0t: out_value expected %0d, got %0d",
                                 $time, head.val, out_value);
                    end
                    if (advanced !== head.adv)
                    begin
                        mismatch_count++;
                        $display("%0t: advanced expected %0b, got %0b",
                                 $time, head.adv, advanced);
                    end
                    if (last !== head.is_last)
                    begin
                        mismatch_count++;
                        $display("%0t: last expected %0b, got %0b",
                                 $time, head.is_last, last);
                    end
                end
            end
            // an item taken at the same edge as a length write still sees the old length
            if (in_valid && in_ready)
            begin
                if (cmd == CMD_ADVANCE)
                begin
                    n = (length_reg > MAX_LEN) ? MAX_LEN : int'(length_reg);
                    if (n > 0)
                    begin
                        moved = advance_copy(n);
                        for (int k = 0; k < n; k++)
                        begin
                            rec.pos     = k[POS_W-1:0];
                            rec.val     = seq_copy[k];
                            rec.adv     = moved;
                            rec.is_last = (k == n - 1);
                            elems_due.insert(elems_due.size(), rec);
                        end
                    end
                end
                else if (position < MAX_LEN)
                begin
                    seq_copy[position] = value;
                end
            end
            if (cfg_valid && cfg_ready)
                length_reg = cfg_data;
        end
        results_due = elems_due.size();
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// testbench top for the next lexicographic permutation unit: stimulus and verdict
// depends on nlp_pkg, the unit itself and nlp_perm_checker
module tb;

    import nlp_pkg::*;

    localparam int RANDOM_ITEMS  = 470;
    // settling time that covers an advance still in flight
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 1000000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_ready;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    logic             out_valid;
    logic             out_ready;
    logic [POS_W-1:0] out_position;
    logic [VAL_W-1:0] out_value;
    logic             advanced;
    logic             last;

    int mismatch_count;
    int results_due;
    int cycle_count = 0;
    int random_sent = 0;
    // cleared for whole phases so that some stretches run with no gaps at all
    bit stall_on    = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    next_lexicographic_permutation_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .position     (position),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_position (out_position),
        .out_value    (out_value),
        .advanced     (advanced),
        .last         (last)
    );

    nlp_perm_checker perm_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_position   (out_position),
        .out_value      (out_value),
        .advanced       (advanced),
        .last           (last),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    // hard stop in case the unit hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[next_lexicographic_permutation_unit] ERROR");
            $finish;
        end
    end

    // offer one item after a random gap and hold it until taken;
    // called at a rising edge and returns at the edge that accepts it
    task automatic send_item(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                             input logic [VAL_W-1:0] v);
        int gap;
        gap = stall_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        position <= p;
        value    <= v;
        do @(posedge clk); while (!in_ready);
    endtask

    // the length register is only touched once the unit has gone quiet:
    // every element emitted, then room for a zero-length advance to finish
    task automatic write_length(input logic [CFG_W-1:0] len);
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // result side: random hold-off before each element is taken
    initial
    begin : drain
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = stall_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0] len_sel;
        int               eff_len;
        int               span;
        int               base;
        int               roll;

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        cmd       <= CMD_LOAD;
        position  <= '0;
        value     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // zero length: an advance emits nothing and reads no element
        write_length(5'd0);
        send_item(CMD_ADVANCE, 4'd15, 8'd255);

        // single element: never a next permutation, one element with last set
        write_length(5'd1);
        send_item(CMD_LOAD, 4'd0, 8'd255);
        send_item(CMD_ADVANCE, 4'd0, 8'd0);

        // strictly falling sequence is already the last permutation
        write_length(5'd3);
        send_item(CMD_LOAD, 4'd1, 8'd128);
        send_item(CMD_LOAD, 4'd2, 8'd0);
        send_item(CMD_ADVANCE, 4'd7, 8'd85);

        // repeated values: 0 128 0 moves on to 128 0 0, which is then the last
        send_item(CMD_LOAD, 4'd0, 8'd0);
        send_item(CMD_ADVANCE, 4'd8, 8'd170);
        send_item(CMD_ADVANCE, 4'd0, 8'd0);

        // fill the rest of the store so every later advance reads written entries
        for (int k = 3; k < MAX_LEN - 1; k++)
            send_item(CMD_LOAD, k[POS_W-1:0], VAL_W'($urandom_range(0, 255)));
        send_item(CMD_LOAD, 4'd15, 8'd255);

        // a length above the store size is clipped to the full sixteen
        write_length(5'd31);
        send_item(CMD_ADVANCE, 4'd0, 8'd0);
        write_length(5'd16);
        send_item(CMD_ADVANCE, 4'd15, 8'd255);

        // random phases: mostly short sequences so advances walk far through
        // their permutations and wrap onto the last one
        while (random_sent < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
                len_sel = CFG_W'($urandom_range(0, 1));
            else if (roll == 1)
                len_sel = CFG_W'($urandom_range(16, 31));
            else if (roll == 2)
                len_sel = CFG_W'($urandom_range(7, 15));
            else
                len_sel = CFG_W'($urandom_range(2, 6));
            write_length(len_sel);
            stall_on = ($urandom_range(0, 3) != 0);
            eff_len  = (len_sel > MAX_LEN) ? MAX_LEN : int'(len_sel);

            // half the phases start from a sorted sequence, pairs of equal values
            if (eff_len > 1 && $urandom_range(0, 1))
            begin
                base = $urandom_range(0, 240);
                for (int k = 0; k < eff_len; k++)
                    send_item(CMD_LOAD, k[POS_W-1:0], VAL_W'(base + k / 2));
                random_sent += eff_len;
            end

            span = $urandom_range(8, 30);
            for (int k = 0; k < span; k++)
            begin
                if ($urandom_range(0, 9) < 7)
                    send_item(CMD_ADVANCE, POS_W'($urandom_range(0, 15)),
                              VAL_W'($urandom_range(0, 255)));
                else if ($urandom_range(0, 1))
                    send_item(CMD_LOAD, POS_W'($urandom_range(0, 15)),
                              VAL_W'($urandom_range(0, 3)));
                else
                    send_item(CMD_LOAD, POS_W'($urandom_range(0, 15)),
                              VAL_W'($urandom_range(0, 255)));
                random_sent++;
            end
        end

        // drain everything still due, then allow for a trailing advance
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && results_due == 0)
            $display("[next_lexicographic_permutation_unit] OK");
        else
            $display("[next_lexicographic_permutation_unit] ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/nlp_pkg.sv
rtl/nlp_ram.sv
rtl/next_lexicographic_permutation_unit.sv
sim/nlp_perm_checker.sv
sim/tb.sv
